// ===== design/arplt_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP learning table package
// Field widths, protocol codes and result codes for the ARP learning table.
// ----------------------------------------------------------------------------
package arplt_pkg;

	// Field widths of one frame summary and of one result.
	localparam int ETYPE_W   = 16;
	localparam int OPCODE_W  = 16;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int OUTCOME_W = 3;
	localparam int SLOT_W    = 7;

	// One table row holds the sender IP above the sender MAC.
	localparam int ROW_W = IP_W + MAC_W;

	// Protocol codes.
	localparam logic [ETYPE_W-1:0]  ETYPE_ARP    = 16'h0806;
	localparam logic [OPCODE_W-1:0] OPCODE_REPLY = 16'd2;

	// Result codes.
	localparam logic [OUTCOME_W-1:0] OUT_NOT_ARP   = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_NOT_REPLY = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_UPDATED   = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_INSERTED  = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd4;

endpackage

// ===== design/arp_reply_learning_table.sv =====
// A non-reply frame goes from idle straight to the finish state and from there
// to the output register; an ARP reply first scans the filled rows.
// The block takes one frame at a time; the scan reads one row per cycle through
// the single read port.
// Reset clears the fill count (all rows invalid); row contents stay undefined
// and no clearing pass runs, so the block takes frames right after reset.
// ----------------------------------------------------------------------------
// ARP reply learning table
// Learns sender IP to MAC bindings from ARP replies in a table memory,
// updating a known address in place or filling the lowest free row.
// ----------------------------------------------------------------------------
module arp_reply_learning_table #(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [arplt_pkg::ETYPE_W-1:0]   eth_type,
	input  logic [arplt_pkg::OPCODE_W-1:0]  arp_opcode,
	input  logic [arplt_pkg::IP_W-1:0]      src_ip,
	input  logic [arplt_pkg::MAC_W-1:0]     src_mac,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [arplt_pkg::OUTCOME_W-1:0] outcome,
	output logic [arplt_pkg::SLOT_W-1:0]    slot
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [arplt_pkg::ROW_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [IDX_W-1:0]            mem_raddr;
	logic [arplt_pkg::ROW_W-1:0] mem_rdata;

	// Table rows: sender IP and MAC side by side.
	arplt_ram #(
		.DEPTH  (TABLE_ENTRIES),
		.WIDTH  (arplt_pkg::ROW_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Classification, scan, update and result register.
	arplt_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W),
		.CNT_W         (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.eth_type   (eth_type),
		.arp_opcode (arp_opcode),
		.src_ip     (src_ip),
		.src_mac    (src_mac),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.outcome    (outcome),
		.slot       (slot),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// A row is written only while a frame is in progress.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> in_stall)
		else $error("table row written while the block takes a new frame");

	// The scan never reads in the cycle of a row write.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("table read and write in the same cycle");

	// Every row write is followed by an update or insert result.
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> out_valid &&
			(outcome == arplt_pkg::OUT_UPDATED || outcome == arplt_pkg::OUT_INSERTED))
		else $error("row write without a matching result");

	// Results that touch no row carry slot zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == arplt_pkg::OUT_NOT_ARP ||
			outcome == arplt_pkg::OUT_NOT_REPLY || outcome == arplt_pkg::OUT_FULL)
		|-> slot == '0)
		else $error("nonzero slot on a result that changed no row");

endmodule

// ===== design/arplt_ram.sv =====
// ----------------------------------------------------------------------------
// ARP learning table row memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module arplt_ram #(
	parameter int DEPTH  = 128,
	parameter int WIDTH  = 80,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/arplt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ARP learning table controller
// Classifies each frame summary; for ARP replies it scans the filled rows for
// the sender IP, updates or inserts a row if it can, and presents the result.
// ----------------------------------------------------------------------------
module arplt_ctrl #(
	parameter int TABLE_ENTRIES = 128,
	parameter int IDX_W         = 7,
	parameter int CNT_W         = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Frame summary channel.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [arplt_pkg::ETYPE_W-1:0]   eth_type,
	input  logic [arplt_pkg::OPCODE_W-1:0]  arp_opcode,
	input  logic [arplt_pkg::IP_W-1:0]      src_ip,
	input  logic [arplt_pkg::MAC_W-1:0]     src_mac,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [arplt_pkg::OUTCOME_W-1:0] outcome,
	output logic [arplt_pkg::SLOT_W-1:0]    slot,
	// Table memory ports.
	output logic                            mem_we,
	output logic [IDX_W-1:0]                mem_waddr,
	output logic [arplt_pkg::ROW_W-1:0]     mem_wdata,
	output logic                            mem_re,
	output logic [IDX_W-1:0]                mem_raddr,
	input  logic [arplt_pkg::ROW_W-1:0]     mem_rdata
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

	logic [1:0]                        state_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  scan_addr_q;
	logic                              rd_pend_s1;
	logic [IDX_W-1:0]                  rd_idx_s1;
	logic                              match_q;
	logic [IDX_W-1:0]                  match_idx_q;
	logic                              is_reply_q;
	logic [arplt_pkg::OUTCOME_W-1:0]   class_q;
	logic [arplt_pkg::IP_W-1:0]        ip_q;
	logic [arplt_pkg::MAC_W-1:0]       mac_q;
	logic                              out_valid_q;
	logic [arplt_pkg::OUTCOME_W-1:0]   outcome_q;
	logic [arplt_pkg::SLOT_W-1:0]      slot_q;

	logic                              accept;
	logic                              hit;
	logic                              scan_done;
	logic                              load_out;
	logic                              has_room;
	logic [arplt_pkg::IP_W-1:0]        rd_ip;
	logic [arplt_pkg::OUTCOME_W-1:0]   res_outcome;
	logic [IDX_W-1:0]                  res_idx;
	logic [arplt_pkg::SLOT_W+IDX_W-1:0] res_idx_ext;

	// Handshake on the input side: one frame summary at a time.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Scan read pipeline: issue one row read per cycle, compare in the next cycle.
	assign rd_ip     = mem_rdata[arplt_pkg::ROW_W-1 -: arplt_pkg::IP_W];
	assign hit       = rd_pend_s1 && (rd_ip == ip_q);
	assign mem_re    = (state_q == ST_SCAN) && (scan_addr_q < count_q) && !hit;
	assign mem_raddr = scan_addr_q[IDX_W-1:0];
	assign scan_done = !rd_pend_s1 && (scan_addr_q == count_q);

	// Result of a finished item and the row write that goes with it.
	assign has_room = (count_q != FULL_COUNT);
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		res_outcome = class_q;
		res_idx     = '0;
		mem_we      = 1'b0;
		if (is_reply_q) begin
			priority if (match_q) begin
				res_outcome = arplt_pkg::OUT_UPDATED;
				res_idx     = match_idx_q;
				mem_we      = load_out;
			end else if (has_room) begin
				res_outcome = arplt_pkg::OUT_INSERTED;
				res_idx     = count_q[IDX_W-1:0];
				mem_we      = load_out;
			end else begin
				res_outcome = arplt_pkg::OUT_FULL;
			end
		end
	end

	assign res_idx_ext = {{arplt_pkg::SLOT_W{1'b0}}, res_idx};
	assign mem_waddr   = res_idx;
	assign mem_wdata   = {ip_q, mac_q};

	// Sequencer and fill count. Rows are only ever added at the fill count,
	// so rows below it are exactly the valid ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_addr_q <= '0;
			rd_pend_s1  <= 1'b0;
			match_q     <= 1'b0;
			is_reply_q  <= 1'b0;
		end else begin
			rd_pend_s1 <= mem_re;
			if (mem_re) begin
				scan_addr_q <= scan_addr_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_addr_q <= '0;
						match_q     <= 1'b0;
						is_reply_q  <= 1'b0;
						if (eth_type != arplt_pkg::ETYPE_ARP ||
						    arp_opcode != arplt_pkg::OPCODE_REPLY) begin
							state_q <= ST_FINISH;
						end else begin
							is_reply_q <= 1'b1;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						match_q <= 1'b1;
						state_q <= ST_FINISH;
					end else if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
						if (is_reply_q && !match_q && has_room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured frame fields and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q  <= src_ip;
			mac_q <= src_mac;
			if (eth_type != arplt_pkg::ETYPE_ARP) begin
				class_q <= arplt_pkg::OUT_NOT_ARP;
			end else begin
				class_q <= arplt_pkg::OUT_NOT_REPLY;
			end
		end
		if (mem_re) begin
			rd_idx_s1 <= scan_addr_q[IDX_W-1:0];
		end
		if (hit) begin
			match_idx_q <= rd_idx_s1;
		end
	end

	// Output register: holds the result until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			outcome_q <= res_outcome;
			slot_q    <= res_idx_ext[arplt_pkg::SLOT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;
	assign slot      = slot_q;

endmodule
